// File: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue cell chain
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 8;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } spq_op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_t;

    typedef struct packed
    {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } spq_entry_t;

    typedef struct packed
    {
        logic ins;
        logic rem;
    } spq_ctrl_t;

endpackage

// File: design/sorted_priority_queue.sv
// a result is registered and valid in the cycle after its request transfer
// throughput: one insert or remove per cycle while the result side takes transfers
// each cell of the chain compares its priority and shifts in the same cycle
// reset clears the entry count and the result valid flag; cell contents stay undefined
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue kept sorted in a chain of shifting cells
// ----------------------------------------------------------------------------
module sorted_priority_queue
#(
    parameter int QUEUE_DEPTH = 128
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic                                  op,
    input  logic signed [spq_pkg::VALUE_W-1:0]    item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]     item_priority,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic [spq_pkg::STATUS_W-1:0]          status,
    output logic signed [spq_pkg::VALUE_W-1:0]    removed_value,
    output logic signed [spq_pkg::PRIO_W-1:0]     removed_priority,
    output logic [spq_pkg::OCC_W-1:0]             occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    spq_status_t                 status_reg;
    spq_status_t                 status_next;
    spq_entry_t                  removed_reg;
    spq_entry_t                  removed_next;
    logic [OCC_W-1:0]            occ_reg;
    logic [OCC_W-1:0]            occ_next;
    logic [CNT_W+OCC_W-1:0]      count_ext;

    logic                        accept;
    logic                        full;
    logic                        empty;
    spq_ctrl_t                   ctrl;
    spq_entry_t                  new_entry;
    spq_entry_t                  cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]      cell_gt;
    logic [QUEUE_DEPTH-1:0]      occupied;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    assign new_entry.value = item_value;
    assign new_entry.prio  = item_priority;

    assign ctrl.ins = accept && (spq_op_t'(op) == OP_INSERT) && !full;
    assign ctrl.rem = accept && (spq_op_t'(op) == OP_REMOVE) && !empty;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            spq_entry_t left_entry;
            logic       left_gt;
            spq_entry_t right_entry;

            assign occupied[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_head
                assign left_entry = new_entry;
                assign left_gt    = 1'b0;
            end
            else
            begin : g_body
                assign left_entry = cell_entry[i-1];
                assign left_gt    = cell_gt[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_entry = cell_entry[i];
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[i+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied[i]),
                .new_entry   (new_entry),
                .left_entry  (left_entry),
                .left_gt     (left_gt),
                .right_entry (right_entry),
                .entry       (cell_entry[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.rem)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_ext = {{OCC_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        removed_next   = removed_reg;
        occ_next       = occ_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            status_next    = ST_DONE;
            removed_next   = '0;
            occ_next       = count_ext[OCC_W-1:0];
            if (spq_op_t'(op) == OP_INSERT)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
            end
            else if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                removed_next = cell_entry[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        occ_reg     <= occ_next;
    end

    assign rsp_valid        = rsp_valid_reg;
    assign status           = status_reg;
    assign removed_value    = removed_reg.value;
    assign removed_priority = removed_reg.prio;
    assign occupancy        = occ_reg;

endmodule

// File: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: keeps, takes the new entry, or shifts
// ----------------------------------------------------------------------------
module spq_cell
(
    input  logic               clk,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  logic               occupied,
    input  spq_pkg::spq_entry_t new_entry,
    input  spq_pkg::spq_entry_t left_entry,
    input  logic               left_gt,
    input  spq_pkg::spq_entry_t right_entry,
    output spq_pkg::spq_entry_t entry,
    output logic               gt
);
    import spq_pkg::*;

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // empty slots count as greater so the first free slot takes the insert
    assign gt = !occupied || ($signed(entry_reg.prio) > $signed(new_entry.prio));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (gt && !left_gt)
            begin
                entry_next = new_entry;
            end
            else if (gt)
            begin
                entry_next = left_entry;
            end
        end
        else if (ctrl.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: verif/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// self-checking bench for the sorted priority queue: a scoreboard keeps its own
// sorted copy of the queue, predicts every response and checks each field, while
// directed and random insert/remove traffic runs under random and held-off stalls
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

    import spq_pkg::*;

    localparam int DEPTH       = 128;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed
    {
        spq_status_t               status;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
        logic [OCC_W-1:0]          occupancy;
    } outcome_t;

    class sorted_queue_scoreboard;
        spq_entry_t  cells[DEPTH];
        int unsigned cell_count;
        outcome_t    due_outcomes[$];
        int          mismatches;

        function new();
            cell_count = 0;
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        function void note_request(spq_op_t o, logic signed [VALUE_W-1:0] v,
                                   logic signed [PRIO_W-1:0] p);
            outcome_t    res;
            int unsigned pos;
            res = '{status: ST_DONE, value: '0, prio: '0, occupancy: '0};
            if (o == OP_INSERT)
            begin
                if (cell_count >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < cell_count && cells[pos].prio <= p)
                        pos++;
                    for (int unsigned k = cell_count; k > pos; k--)
                        cells[k] = cells[k-1];
                    cells[pos].value = v;
                    cells[pos].prio  = p;
                    cell_count++;
                end
            end
            else
            begin
                if (cell_count == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.value = cells[0].value;
                    res.prio  = cells[0].prio;
                    for (int unsigned k = 0; k + 1 < cell_count; k++)
                        cells[k] = cells[k+1];
                    cell_count--;
                end
            end
            res.occupancy = cell_count[OCC_W-1:0];
            due_outcomes.push_back(res);
        endfunction

        task check_response(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] v,
                            logic signed [PRIO_W-1:0] p, logic [OCC_W-1:0] occ);
            outcome_t want;
            if (due_outcomes.size() == 0)
            begin
                report("response with no request outstanding");
                return;
            end
            want = due_outcomes.pop_front();
            if (st !== want.status)
                report($sformatf("status got %0d want %0d", st, want.status));
            if (v !== want.value)
                report($sformatf("removed_value got %0d want %0d", v, want.value));
            if (p !== want.prio)
                report($sformatf("removed_priority got %0d want %0d", p, want.prio));
            if (occ !== want.occupancy)
                report($sformatf("occupancy got %0d want %0d", occ, want.occupancy));
        endtask

        function int outstanding();
            return due_outcomes.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_stall;
    logic                       op;
    logic signed [VALUE_W-1:0]  item_value;
    logic signed [PRIO_W-1:0]   item_priority;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  removed_value;
    logic signed [PRIO_W-1:0]   removed_priority;
    logic [OCC_W-1:0]           occupancy;

    sorted_queue_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    logic hold_rsp;
    int  cycle_count = 0;

    sorted_priority_queue
    #(
        .QUEUE_DEPTH(DEPTH)
    )
    uut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .op               (op),
        .item_value       (item_value),
        .item_priority    (item_priority),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .status           (status),
        .removed_value    (removed_value),
        .removed_priority (removed_priority),
        .occupancy        (occupancy)
    );

    always #1 clk = ~clk;

    // response side: check the transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_response(status, removed_value, removed_priority, occupancy);
        if (hold_rsp)
            rsp_stall <= 1'b1;
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_sorted_priority_queue: done, errors");
            $finish;
        end
    end

    task automatic send_item(spq_op_t o, logic signed [VALUE_W-1:0] v,
                             logic signed [PRIO_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        op            <= o;
        item_value    <= v;
        item_priority <= p;
        do
            @(posedge clk);
        while (req_stall);
        board.note_request(o, v, p);
    endtask

    function automatic logic signed [PRIO_W-1:0] pick_priority();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return PRIO_W'($signed($urandom_range(8)) - 4);
        else if (sel < 5)
        begin
            case ($urandom_range(3))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        return PRIO_W'($urandom);
    endfunction

    task automatic send_random(int insert_pct);
        spq_op_t o;
        o = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        send_item(o, VALUE_W'($urandom), pick_priority());
    endtask

    task automatic run_phase();
        repeat (DEPTH + 6) send_random(100);
        repeat (DEPTH + 6) send_random(0);
        repeat (130) send_random(70);
        repeat (120) send_random(50);
        repeat (120) send_random(30);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        board         = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_rsp      <= 1'b0;
        req_valid     <= 1'b0;
        op            <= OP_INSERT;
        item_value    <= '0;
        item_priority <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty remove, field extremes, ties at both ends of the range
        send_item(OP_REMOVE, 32'sh7fffffff, 16'sh7fff);
        send_item(OP_INSERT, 32'sh7fffffff, 16'sh7fff);
        send_item(OP_INSERT, 32'sh80000000, 16'sh8000);
        send_item(OP_INSERT, 32'sh00000000, 16'sh0000);
        send_item(OP_INSERT, 32'shffffffff, 16'shffff);
        send_item(OP_INSERT, 32'sh55555555, 16'sh0000);
        send_item(OP_INSERT, 32'shaaaaaaaa, 16'sh0000);
        send_item(OP_INSERT, 32'sh00000001, 16'sh7fff);
        send_item(OP_INSERT, 32'sh00000002, 16'sh8000);
        repeat (8) send_item(OP_REMOVE, 32'sh0, 16'sh0);
        send_item(OP_REMOVE, 32'sh80000000, 16'sh8000);

        send_idle_pct = 22;
        recv_idle_pct = 72;
        run_phase();

        send_idle_pct = 72;
        recv_idle_pct = 22;
        run_phase();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long response hold-off so the queue backs up into its request side
        fork
            begin
                hold_rsp <= 1'b1;
                repeat (400) @(posedge clk);
                hold_rsp <= 1'b0;
            end
        join_none
        run_phase();

        req_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.mismatches == 0)
            $display("tb_sorted_priority_queue: done, clean");
        else
            $display("tb_sorted_priority_queue: done, errors");
        $finish;
    end

endmodule
